FILE: design/ldc_pkg.sv
// Shared types and fixed widths for the linear detrend block.
// No dependencies.
`default_nettype none
package ldc_pkg;
  localparam int MUL_A_W = 64;
  localparam int MUL_B_W = 22;
  localparam int DIV_N_W = 64;
  localparam int DIV_D_W = 46;
  localparam int SUM_W   = 22;
  localparam int SQ_W    = 38;

  typedef struct packed {
    logic signed [15:0] x_value;
    logic signed [15:0] y_value;
    logic               last_point;
  } ldc_in_t;

  typedef struct packed {
    logic signed [15:0] residual;
    logic               last_residual;
  } ldc_out_t;
endpackage
`default_nettype wire

FILE: design/linear_detrend_curve.sv
// Top level of the least-squares linear detrend; uses ldc_pkg, ldc_pmem,
// ldc_mul and ldc_div.
//
// Points load at one beat per cycle into a point memory while running sums
// build up. A beat flagged last_point closes the curve: six serial multiplies
// form the determinant and fit numerators, then each stored point is read
// back in turn and takes one or two serial multiplies and a serial divide
// on the single multiplier and divider, one point at a time. No input is
// taken during fit and emission.
`default_nettype none
module linear_detrend_curve #(
  parameter int MAX_POINTS = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire ldc_pkg::ldc_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output ldc_pkg::ldc_out_t      out_data
);
  import ldc_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  localparam logic [2:0] S_LOAD   = 3'd0;
  localparam logic [2:0] S_FIT_GO = 3'd1;
  localparam logic [2:0] S_FIT_WT = 3'd2;
  localparam logic [2:0] S_RD     = 3'd3;
  localparam logic [2:0] S_RDW    = 3'd4;
  localparam logic [2:0] S_PM     = 3'd5;
  localparam logic [2:0] S_DIV    = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  logic [2:0]                state_r;
  logic [CW-1:0]             cnt_r;
  logic [CW-1:0]             idx_r;
  logic [2:0]                fstep_r;
  logic                      pm2_r;
  logic                      dstart_r;
  logic                      mstart_r;
  logic signed [SUM_W-1:0]   sum_x_r;
  logic signed [SUM_W-1:0]   sum_y_r;
  logic signed [SQ_W-1:0]    sum_xx_r;
  logic signed [SQ_W-1:0]    sum_xy_r;
  logic signed [MUL_A_W-1:0] ma_r;
  logic signed [MUL_B_W-1:0] mb_r;
  logic signed [MUL_A_W-1:0] tmp_r;
  logic signed [MUL_A_W-1:0] det_r;
  logic signed [MUL_A_W-1:0] offs_r;
  logic signed [MUL_A_W-1:0] slope_r;
  logic signed [MUL_A_W-1:0] num_r;
  logic signed [15:0]        xs_r;
  logic                      out_valid_r;
  ldc_out_t                  out_r;

  logic                      accept;
  logic                      full;
  logic                      det_pos;
  logic                      mdone;
  logic signed [MUL_A_W-1:0] mp;
  logic                      ddone;
  logic [DIV_N_W-1:0]        dq;
  logic [DIV_N_W-1:0]        mag;
  logic [44:0]               den;
  logic [DIV_N_W-1:0]        dvd;
  logic [31:0]               rdata;
  logic signed [15:0]        rd_x;
  logic signed [15:0]        rd_y;
  logic signed [31:0]        xx;
  logic signed [31:0]        xy;
  logic                      is_last;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_LOAD);
  assign full     = (cnt_r == CW'(MAX_POINTS));
  assign det_pos  = (det_r != '0);
  assign rd_x     = rdata[31:16];
  assign rd_y     = rdata[15:0];
  assign xx       = in_data.x_value * in_data.x_value;
  assign xy       = in_data.x_value * in_data.y_value;
  assign mag      = num_r[MUL_A_W-1] ? DIV_N_W'(-num_r) : DIV_N_W'(num_r);
  assign den      = det_pos ? det_r[44:0] : 45'(cnt_r);
  assign dvd      = {mag[DIV_N_W-2:0], 1'b0} + DIV_N_W'(den);
  assign is_last  = (idx_r == cnt_r - 1'b1);

  ldc_pmem #(.DEPTH(MAX_POINTS), .AW(AW)) u_pmem (
    .clk   (clk),
    .we    (accept && !full),
    .waddr (cnt_r[AW-1:0]),
    .wdata ({in_data.x_value, in_data.y_value}),
    .raddr (idx_r[AW-1:0]),
    .rdata (rdata)
  );

  ldc_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mstart_r),
    .a     (ma_r),
    .b     (mb_r),
    .done  (mdone),
    .p     (mp)
  );

  ldc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dstart_r),
    .num   (dvd),
    .den   ({den, 1'b0}),
    .done  (ddone),
    .q     (dq)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      idx_r       <= '0;
      fstep_r     <= '0;
      pm2_r       <= 1'b0;
      mstart_r    <= 1'b0;
      dstart_r    <= 1'b0;
      out_valid_r <= 1'b0;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      sum_xx_r    <= '0;
      sum_xy_r    <= '0;
    end else begin
      mstart_r <= 1'b0;
      dstart_r <= 1'b0;
      case (state_r)
        S_LOAD: begin
          if (accept) begin
            if (!full) begin
              cnt_r    <= cnt_r + 1'b1;
              sum_x_r  <= sum_x_r + SUM_W'(in_data.x_value);
              sum_y_r  <= sum_y_r + SUM_W'(in_data.y_value);
              sum_xx_r <= sum_xx_r + SQ_W'(xx);
              sum_xy_r <= sum_xy_r + SQ_W'(xy);
            end
            if (in_data.last_point) begin
              fstep_r <= '0;
              state_r <= S_FIT_GO;
            end
          end
        end
        S_FIT_GO: begin
          case (fstep_r)
            3'd0: begin ma_r <= MUL_A_W'(sum_xx_r); mb_r <= MUL_B_W'(cnt_r);  end
            3'd1: begin ma_r <= MUL_A_W'(sum_x_r);  mb_r <= sum_x_r;          end
            3'd2: begin ma_r <= MUL_A_W'(sum_xx_r); mb_r <= sum_y_r;          end
            3'd3: begin ma_r <= MUL_A_W'(sum_xy_r); mb_r <= sum_x_r;          end
            3'd4: begin ma_r <= MUL_A_W'(sum_xy_r); mb_r <= MUL_B_W'(cnt_r);  end
            default: begin ma_r <= MUL_A_W'(sum_x_r); mb_r <= sum_y_r;        end
          endcase
          mstart_r <= 1'b1;
          state_r  <= S_FIT_WT;
        end
        S_FIT_WT: begin
          if (mdone) begin
            case (fstep_r)
              3'd1: det_r <= tmp_r - mp;
              3'd3: offs_r <= tmp_r - mp;
              3'd5: slope_r <= tmp_r - mp;
              default: tmp_r <= mp;
            endcase
            if (fstep_r == 3'd5) begin
              idx_r   <= '0;
              state_r <= S_RD;
            end else begin
              fstep_r <= fstep_r + 1'b1;
              state_r <= S_FIT_GO;
            end
          end
        end
        S_RD: begin
          state_r <= S_RDW;
        end
        S_RDW: begin
          xs_r <= rd_x;
          if (det_pos) begin
            ma_r <= det_r;
            mb_r <= MUL_B_W'(rd_y);
          end else begin
            ma_r <= MUL_A_W'(rd_y);
            mb_r <= MUL_B_W'(cnt_r);
          end
          pm2_r    <= 1'b0;
          mstart_r <= 1'b1;
          state_r  <= S_PM;
        end
        S_PM: begin
          if (mdone) begin
            if (!det_pos) begin
              num_r    <= mp - MUL_A_W'(sum_y_r);
              dstart_r <= 1'b1;
              state_r  <= S_DIV;
            end else if (!pm2_r) begin
              tmp_r    <= mp - offs_r;
              ma_r     <= slope_r;
              mb_r     <= MUL_B_W'(xs_r);
              pm2_r    <= 1'b1;
              mstart_r <= 1'b1;
            end else begin
              num_r    <= tmp_r - mp;
              dstart_r <= 1'b1;
              state_r  <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (ddone) begin
            if (num_r[MUL_A_W-1]) begin
              out_r.residual <= (dq > DIV_N_W'(32768)) ? 16'sh8000 : -$signed(dq[15:0]);
            end else begin
              out_r.residual <= (dq > DIV_N_W'(32767)) ? 16'sh7fff : $signed(dq[15:0]);
            end
            out_r.last_residual <= is_last;
            out_valid_r         <= 1'b1;
            state_r             <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            if (is_last) begin
              cnt_r    <= '0;
              sum_x_r  <= '0;
              sum_y_r  <= '0;
              sum_xx_r <= '0;
              sum_xy_r <= '0;
              state_r  <= S_LOAD;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= S_RD;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // result beat only shows once the divide has finished
  a_out_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_OUT))
    else $error("result valid outside emission");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_POINTS))
    else $error("point count overflow");

  a_last_fit: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.last_point) |=> (state_r == S_FIT_GO))
    else $error("last point did not start the fit");

  a_mul_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mstart_r |=> !mdone)
    else $error("multiplier finished too early");
endmodule
`default_nettype wire

FILE: design/ldc_pmem.sv
// Point store: one synchronous memory of packed (x, y) pairs, registered read.
// Depends on nothing.
`default_nettype none
module ldc_pmem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [31:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [31:0]   rdata
);
  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: design/ldc_mul.sv
// Shift-add signed multiplier, one multiplier bit per cycle.
// Depends on ldc_pkg.
`default_nettype none
module ldc_mul (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  input  wire logic signed [ldc_pkg::MUL_A_W-1:0]  a,
  input  wire logic signed [ldc_pkg::MUL_B_W-1:0]  b,
  output logic                                     done,
  output logic signed [ldc_pkg::MUL_A_W-1:0]       p
);
  import ldc_pkg::*;
  localparam int CNT_W = $clog2(MUL_B_W);

  logic                      busy_r;
  logic                      done_r;
  logic [CNT_W-1:0]          cnt_r;
  logic signed [MUL_A_W-1:0] a_r;
  logic signed [MUL_B_W-1:0] b_r;
  logic signed [MUL_A_W-1:0] acc_r;
  logic signed [MUL_A_W-1:0] acc_nxt;

  // top bit of b carries negative weight
  always_comb begin
    acc_nxt = acc_r;
    if (b_r[0]) begin
      if (cnt_r == CNT_W'(MUL_B_W - 1)) begin
        acc_nxt = acc_r - a_r;
      end else begin
        acc_nxt = acc_r + a_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r    <= a;
        b_r    <= b;
        acc_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        acc_r <= acc_nxt;
        a_r   <= a_r <<< 1;
        b_r   <= b_r >>> 1;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MUL_B_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign p    = acc_r;
endmodule
`default_nettype wire

FILE: design/ldc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on ldc_pkg.
`default_nettype none
module ldc_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [ldc_pkg::DIV_N_W-1:0]  num,
  input  wire logic [ldc_pkg::DIV_D_W-1:0]  den,
  output logic                              done,
  output logic [ldc_pkg::DIV_N_W-1:0]       q
);
  import ldc_pkg::*;
  localparam int CNT_W = $clog2(DIV_N_W);

  logic                 busy_r;
  logic                 done_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [DIV_N_W-1:0]   dvd_r;
  logic [DIV_N_W-1:0]   q_r;
  logic [DIV_D_W-1:0]   dvs_r;
  logic [DIV_D_W-1:0]   rem_r;
  logic [DIV_D_W:0]     rem_sh;
  logic                 fits;

  assign rem_sh = {rem_r, dvd_r[DIV_N_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        dvd_r  <= num;
        dvs_r  <= den;
        rem_r  <= '0;
        q_r    <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        dvd_r <= dvd_r << 1;
        q_r   <= {q_r[DIV_N_W-2:0], fits};
        if (fits) begin
          rem_r <= DIV_D_W'(rem_sh - {1'b0, dvs_r});
        end else begin
          rem_r <= rem_sh[DIV_D_W-1:0];
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_N_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign q    = q_r;
endmodule
`default_nettype wire
